// ===== rtl/core/bpp_pkg.sv =====
`default_nettype none

package bpp_pkg;

    // Element tags that are captured
    localparam logic [7:0] TAG_TLLI = 8'h1F;
    localparam logic [7:0] TAG_LLC  = 8'h0E;
    localparam logic [7:0] TAG_CELL = 8'h08;

    // A third MNC nibble of this value means a two-digit MNC
    localparam logic [3:0] MNC_ABSENT = 4'hF;

    // Element walk phases
    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // PDU classes
    localparam logic [2:0] CLASS_UL        = 3'd0;
    localparam logic [2:0] CLASS_DL        = 3'd1;
    localparam logic [2:0] CLASS_RESET     = 3'd2;
    localparam logic [2:0] CLASS_RESET_ACK = 3'd3;
    localparam logic [2:0] CLASS_RADIO     = 3'd4;
    localparam logic [2:0] CLASS_OTHER     = 3'd5;

    // Result kinds
    localparam logic ITEM_PAYLOAD = 1'b0;
    localparam logic ITEM_SUMMARY = 1'b1;

    // Capture flag bits
    localparam int FLAG_TLLI = 0;
    localparam int FLAG_LLC  = 1;
    localparam int FLAG_CELL = 2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DL_CODE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UL_CODE        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIO_CODE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_CODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_ACK_CODE = 3'd4;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_pdu;
    } byte_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic        last_item;
        logic [2:0]  pdu_class;
        logic [31:0] tlli_value;
        logic [7:0]  llc_length;
        logic        llc_valid;
        logic [10:0] country_code;
        logic [10:0] network_code;
        logic [15:0] area_code;
        logic [7:0]  routing_area;
        logic [15:0] cell_identity;
    } result_item_t;

    typedef struct packed {
        logic [7:0] dl_unitdata_code;
        logic [7:0] ul_unitdata_code;
        logic [7:0] radio_status_code;
        logic [7:0] bvc_reset_code;
        logic [7:0] bvc_reset_ack_code;
    } codes_t;

    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } push_t;

    typedef struct packed {
        logic                   has_room;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpp_walk.sv =====
`default_nettype none

module bpp_walk (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire bpp_pkg::byte_item_t   item,
    input  wire bpp_pkg::codes_t       codes,
    output bpp_pkg::push_t             push,
    output bpp_pkg::result_item_t      first_item,
    output bpp_pkg::result_item_t      second_item
);
    import bpp_pkg::*;

    logic        first_pending_reg, first_pending_next;
    logic [2:0]  class_reg, class_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [2:0]  found_reg, found_next;
    logic [2:0]  capture_reg, capture_next;
    logic [31:0] tlli_reg, tlli_next;
    logic [2:0]  tlli_count_reg, tlli_count_next;
    logic [63:0] cell_reg, cell_next;
    logic [3:0]  cell_count_reg, cell_count_next;
    logic [7:0]  llc_len_reg, llc_len_next;

    logic        payload_hit;
    logic [7:0]  b;

    result_item_t payload_item;
    result_item_t summary_item;

    function automatic logic [2:0] classify(input logic [7:0] t, input codes_t c);
        logic [2:0] k;
        priority if (t == c.ul_unitdata_code)   k = CLASS_UL;
        else if (t == c.dl_unitdata_code)       k = CLASS_DL;
        else if (t == c.bvc_reset_code)         k = CLASS_RESET;
        else if (t == c.bvc_reset_ack_code)     k = CLASS_RESET_ACK;
        else if (t == c.radio_status_code)      k = CLASS_RADIO;
        else                                    k = CLASS_OTHER;
        return k;
    endfunction

    function automatic logic [10:0] times10(input logic [3:0] n);
        return ({7'd0, n} << 3) + ({7'd0, n} << 1);
    endfunction

    function automatic logic [10:0] times100(input logic [3:0] n);
        return {7'd0, n} * 11'd100;
    endfunction

    assign b = item.data_byte;

    always_comb
    begin
        logic [2:0] cap;
        cap                = 3'd0;
        first_pending_next = first_pending_reg;
        class_next         = class_reg;
        phase_next         = phase_reg;
        tag_next           = tag_reg;
        remaining_next     = remaining_reg;
        found_next         = found_reg;
        capture_next       = capture_reg;
        tlli_next          = tlli_reg;
        tlli_count_next    = tlli_count_reg;
        cell_next          = cell_reg;
        cell_count_next    = cell_count_reg;
        llc_len_next       = llc_len_reg;
        payload_hit        = 1'b0;

        if (first_pending_reg)
        begin
            class_next         = classify(b, codes);
            phase_next         = PH_TAG;
            tag_next           = 8'd0;
            remaining_next     = 8'd0;
            found_next         = 3'd0;
            capture_next       = 3'd0;
            tlli_next          = 32'd0;
            tlli_count_next    = 3'd0;
            cell_next          = 64'd0;
            cell_count_next    = 4'd0;
            llc_len_next       = 8'd0;
            first_pending_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    remaining_next = b;
                    if (tag_reg == TAG_TLLI && !found_reg[FLAG_TLLI])
                    begin
                        cap[FLAG_TLLI]  = 1'b1;
                        tlli_next       = 32'd0;
                        tlli_count_next = 3'd0;
                    end
                    if (tag_reg == TAG_LLC && !found_reg[FLAG_LLC])
                    begin
                        cap[FLAG_LLC] = 1'b1;
                        llc_len_next  = b;
                    end
                    if (tag_reg == TAG_CELL && !found_reg[FLAG_CELL])
                    begin
                        cap[FLAG_CELL]  = 1'b1;
                        cell_next       = 64'd0;
                        cell_count_next = 4'd0;
                    end
                    if (b == 8'd0)
                    begin
                        // An empty element is complete at once.
                        found_next   = found_reg | cap;
                        capture_next = 3'd0;
                        phase_next   = PH_TAG;
                    end
                    else
                    begin
                        capture_next = cap;
                        phase_next   = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (capture_reg[FLAG_TLLI] && tlli_count_reg < 3'd4)
                    begin
                        tlli_next       = {tlli_reg[23:0], b};
                        tlli_count_next = tlli_count_reg + 3'd1;
                    end
                    if (capture_reg[FLAG_LLC] && class_reg <= CLASS_DL)
                    begin
                        payload_hit = 1'b1;
                    end
                    if (capture_reg[FLAG_CELL] && cell_count_reg < 4'd8)
                    begin
                        cell_next       = {cell_reg[55:0], b};
                        cell_count_next = cell_count_reg + 4'd1;
                    end
                    remaining_next = remaining_reg - 8'd1;
                    if (remaining_next == 8'd0)
                    begin
                        found_next   = found_reg | capture_reg;
                        capture_next = 3'd0;
                        phase_next   = PH_TAG;
                    end
                end
                default:
                begin
                    tag_next   = b;
                    phase_next = PH_LEN;
                end
            endcase
        end

        if (item.end_of_pdu)
        begin
            first_pending_next = 1'b1;
        end
    end

    // The summary reflects the state after this octet has been walked.
    always_comb
    begin
        logic [3:0] mcc1, mcc2, mcc3, mnc1, mnc2, mnc3;
        mcc1 = cell_next[59:56];
        mcc2 = cell_next[63:60];
        mcc3 = cell_next[51:48];
        mnc3 = cell_next[55:52];
        mnc1 = cell_next[43:40];
        mnc2 = cell_next[47:44];

        summary_item           = '0;
        summary_item.item_kind = ITEM_SUMMARY;
        summary_item.last_item = 1'b1;
        summary_item.pdu_class = class_next;
        if ((class_next <= CLASS_DL || class_next == CLASS_RADIO)
            && found_next[FLAG_TLLI] && tlli_count_next == 3'd4)
        begin
            summary_item.tlli_value = tlli_next;
        end
        if (class_next <= CLASS_DL && found_next[FLAG_LLC])
        begin
            summary_item.llc_length = llc_len_next;
            summary_item.llc_valid  = 1'b1;
        end
        if (class_next == CLASS_UL && found_next[FLAG_CELL] && cell_count_next == 4'd8)
        begin
            summary_item.country_code = {7'd0, mcc1} + times10(mcc2) + times100(mcc3);
            if (mnc3 == MNC_ABSENT)
            begin
                summary_item.network_code = {7'd0, mnc1} + times10(mnc2);
            end
            else
            begin
                summary_item.network_code = {7'd0, mnc1} + times10(mnc2) + times100(mnc3);
            end
            summary_item.area_code     = cell_next[39:24];
            summary_item.routing_area  = cell_next[23:16];
            summary_item.cell_identity = cell_next[15:0];
        end
    end

    always_comb
    begin
        payload_item              = '0;
        payload_item.item_kind    = ITEM_PAYLOAD;
        payload_item.payload_byte = b;
        payload_item.last_item    = !item.end_of_pdu;
    end

    assign push.first_valid  = accept && (payload_hit || item.end_of_pdu);
    assign push.second_valid = accept && payload_hit && item.end_of_pdu;
    assign first_item        = payload_hit ? payload_item : summary_item;
    assign second_item       = summary_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            class_reg         <= CLASS_UL;
            phase_reg         <= PH_TAG;
            tag_reg           <= 8'd0;
            remaining_reg     <= 8'd0;
            found_reg         <= 3'd0;
            capture_reg       <= 3'd0;
            tlli_reg          <= 32'd0;
            tlli_count_reg    <= 3'd0;
            cell_reg          <= 64'd0;
            cell_count_reg    <= 4'd0;
            llc_len_reg       <= 8'd0;
        end
        else if (accept)
        begin
            first_pending_reg <= first_pending_next;
            class_reg         <= class_next;
            phase_reg         <= phase_next;
            tag_reg           <= tag_next;
            remaining_reg     <= remaining_next;
            found_reg         <= found_next;
            capture_reg       <= capture_next;
            tlli_reg          <= tlli_next;
            tlli_count_reg    <= tlli_count_next;
            cell_reg          <= cell_next;
            cell_count_reg    <= cell_count_next;
            llc_len_reg       <= llc_len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bpp_queue.sv =====
`default_nettype none

module bpp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bpp_pkg::push_t        push,
    input  wire bpp_pkg::result_item_t first_item,
    input  wire bpp_pkg::result_item_t second_item,
    input  wire logic                  pop,
    output bpp_pkg::result_item_t      head_item,
    output bpp_pkg::queue_status_t     status
);
    import bpp_pkg::*;

    result_item_t mem [QUEUE_DEPTH];

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] second_ptr;

    assign second_ptr = wr_ptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.first_valid)
                                 + QUEUE_PTR_W'(push.second_valid);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.first_valid)
                                + QUEUE_CNT_W'(push.second_valid)
                                - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= first_item;
        end
        if (push.second_valid)
        begin
            mem[second_ptr] <= second_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item       = mem[rd_ptr_reg];
    assign status.count    = count_reg;
    // A request may yield two results, so two free slots are required.
    assign status.has_room = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

endmodule

`default_nettype wire

// ===== rtl/core/bssgp_pdu_tlv_parser_core.sv =====
// Results: each result is written into the result queue when its request is accepted and is presented from its head.
// Throughput: one request per cycle; a request that ends an LLC octet and the PDU at once
// yields two results, and ready drops while the four-entry result queue has under two free slots.
// Reset: the parser waits for a type octet, the type codes return to their defaults and the
// result queue is emptied.
`default_nettype none

module bssgp_pdu_tlv_parser_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               byte_valid,
    output logic                                    byte_ready,
    input  wire bpp_pkg::byte_item_t                byte_item,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output bpp_pkg::result_item_t                   result_item,
    input  wire logic                               cfg_we,
    input  wire logic [bpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [7:0]                         cfg_data
);
    import bpp_pkg::*;

    codes_t        codes_reg;
    push_t         push;
    result_item_t  first_item;
    result_item_t  second_item;
    queue_status_t status;
    logic          accept;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.dl_unitdata_code   <= 8'd0;
            codes_reg.ul_unitdata_code   <= 8'd1;
            codes_reg.radio_status_code  <= 8'd10;
            codes_reg.bvc_reset_code     <= 8'd34;
            codes_reg.bvc_reset_ack_code <= 8'd35;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DL_CODE:        codes_reg.dl_unitdata_code   <= cfg_data;
                CFG_UL_CODE:        codes_reg.ul_unitdata_code   <= cfg_data;
                CFG_RADIO_CODE:     codes_reg.radio_status_code  <= cfg_data;
                CFG_RESET_CODE:     codes_reg.bvc_reset_code     <= cfg_data;
                CFG_RESET_ACK_CODE: codes_reg.bvc_reset_ack_code <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign byte_ready   = status.has_room;
    assign accept       = byte_valid && byte_ready;
    assign result_valid = status.count != '0;
    assign pop          = result_valid && result_ready;

    bpp_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (byte_item),
        .codes       (codes_reg),
        .push        (push),
        .first_item  (first_item),
        .second_item (second_item)
    );

    bpp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .first_item  (first_item),
        .second_item (second_item),
        .pop         (pop),
        .head_item   (result_item),
        .status      (status)
    );

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !byte_ready |-> result_valid
    ) else $error("request stalled with an empty result queue");

    a_summary_follows_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && byte_item.end_of_pdu |=> result_valid
    ) else $error("no result after the final octet of a PDU");

    a_queue_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.count <= QUEUE_CNT_W'(QUEUE_DEPTH)
    ) else $error("result queue overflow");

    a_payload_single: assert property (
        @(posedge clk) disable iff (!rst_n)
        push.second_valid |-> push.first_valid && first_item.item_kind == ITEM_PAYLOAD
    ) else $error("second result without a payload octet ahead of it");

endmodule

`default_nettype wire
